// ===== rtl/stream_admission_controller_core_defines.svh =====
// Assertion macros shared by the checker of the stream admission controller.
`ifndef STREAM_ADMISSION_CONTROLLER_CORE_DEFINES_SVH
`define STREAM_ADMISSION_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SAC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SAC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sac_pkg.sv =====
// Types and constants of the stream admission controller.
package sac_pkg;

    localparam int STREAM_INDEX_W = 8;
    localparam int INDEX_SPAN     = 256;
    localparam int CFG_DATA_W     = 16;
    localparam int CAP_W          = 16;
    localparam int OUT_LEVEL_W    = 16;
    localparam int TOTAL_W        = 32;

    typedef enum logic [1:0] {
        ACT_ADMIT    = 2'd0,
        ACT_PROMOTE  = 2'd1,
        ACT_CLOSE    = 2'd2,
        ACT_SHUTDOWN = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        DEC_ADMITTED     = 2'd0,
        DEC_QUEUED       = 2'd1,
        DEC_SHED_ACTIVE  = 2'd2,
        DEC_SHED_BACKLOG = 2'd3
    } decision_t;

    typedef logic [1:0] slot_t;

    // Slot table codes; the fourth code is never written.
    localparam slot_t SLOT_ABSENT  = 2'd0;
    localparam slot_t SLOT_ACTIVE  = 2'd1;
    localparam slot_t SLOT_BACKLOG = 2'd2;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_ACTIVE_CAP     = 2'd0;
    localparam cfg_index_t CFG_BACKLOG_CAP    = 2'd1;
    localparam cfg_index_t CFG_DYNAMIC_CAP    = 2'd2;
    localparam cfg_index_t CFG_DYNAMIC_CAP_EN = 2'd3;

    typedef struct packed {
        logic [CAP_W-1:0] active_limit;
        logic [CAP_W-1:0] backlog_limit;
        logic [CAP_W-1:0] dynamic_cap;
        logic             dynamic_cap_enable;
    } cfg_t;

    typedef struct packed {
        action_t                   action;
        logic [STREAM_INDEX_W-1:0] stream_index;
        logic                      has_stream_id;
        logic                      shutdown_value;
    } req_t;

    typedef struct packed {
        decision_t              decision;
        logic                   promoted;
        logic [OUT_LEVEL_W-1:0] active_now;
        logic [OUT_LEVEL_W-1:0] backlog_now;
        logic [OUT_LEVEL_W-1:0] active_high;
        logic [OUT_LEVEL_W-1:0] backlog_high;
        logic [TOTAL_W-1:0]     offered_total;
        logic [TOTAL_W-1:0]     admitted_total;
        logic [TOTAL_W-1:0]     active_cap_hit_total;
        logic [TOTAL_W-1:0]     backlog_cap_hit_total;
        logic [TOTAL_W-1:0]     shed_total;
        logic                   shutdown_flag;
    } result_t;

    typedef struct packed {
        logic  en;
        slot_t data;
    } tbl_wr_t;

endpackage

// ===== rtl/sac_if.sv =====
// Request and result channel interfaces of the stream admission controller.
interface sac_req_if;
    import sac_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sac_res_if;
    import sac_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sac_slot_table.sv =====
// Per-stream slot table: flop memory with registered read, valid bits and write bypass.
module sac_slot_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output sac_pkg::slot_t rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  sac_pkg::slot_t wr_data
);
    import sac_pkg::*;

    slot_t            mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    slot_t            rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // A write in the same cycle to the entry being read wins over the stored value.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= SLOT_ABSENT;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sac_engine.sv =====
// Admission decision logic with the level, peak, counter and shutdown registers.
module sac_engine #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  sac_pkg::req_t    req,
    input  sac_pkg::slot_t   slot,
    input  sac_pkg::cfg_t    cfg,
    output sac_pkg::result_t result,
    output sac_pkg::tbl_wr_t tbl_wr
);
    import sac_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] c);
        return (&c) ? c : c + TOTAL_W'(1);
    endfunction

    logic [COUNT_WIDTH-1:0] active_level_reg, active_level_next;
    logic [COUNT_WIDTH-1:0] backlog_level_reg, backlog_level_next;
    logic [COUNT_WIDTH-1:0] active_mark_reg, active_mark_next;
    logic [COUNT_WIDTH-1:0] backlog_mark_reg, backlog_mark_next;
    logic [TOTAL_W-1:0]     offered_reg, offered_next;
    logic [TOTAL_W-1:0]     admitted_reg, admitted_next;
    logic [TOTAL_W-1:0]     active_hit_reg, active_hit_next;
    logic [TOTAL_W-1:0]     backlog_hit_reg, backlog_hit_next;
    logic [TOTAL_W-1:0]     shed_reg, shed_next;
    logic                   shutdown_reg, shutdown_next;

    logic [CAP_W-1:0] eff_cap;
    logic             active_room;
    logic             backlog_room;
    decision_t        decision;
    logic             promoted;

    assign eff_cap = (cfg.dynamic_cap_enable && (cfg.dynamic_cap < cfg.active_limit))
                   ? cfg.dynamic_cap : cfg.active_limit;

    // A level at its all-ones value cannot grow, as if the cap were reached.
    assign active_room  = (CMP_W'(active_level_reg) < CMP_W'(eff_cap))
                       && !(&active_level_reg);
    assign backlog_room = (CMP_W'(backlog_level_reg) < CMP_W'(cfg.backlog_limit))
                       && !(&backlog_level_reg);

    always_comb
    begin
        active_level_next  = active_level_reg;
        backlog_level_next = backlog_level_reg;
        offered_next       = offered_reg;
        admitted_next      = admitted_reg;
        active_hit_next    = active_hit_reg;
        backlog_hit_next   = backlog_hit_reg;
        shed_next          = shed_reg;
        shutdown_next      = shutdown_reg;
        decision           = DEC_ADMITTED;
        promoted           = 1'b0;
        tbl_wr             = '0;

        case (req.action)
            ACT_ADMIT:
            begin
                offered_next = sat_inc(offered_reg);
                if (shutdown_reg)
                begin
                    shed_next = sat_inc(shed_reg);
                    decision  = DEC_SHED_ACTIVE;
                end
                else if (active_room)
                begin
                    active_level_next = active_level_reg + COUNT_WIDTH'(1);
                    admitted_next     = sat_inc(admitted_reg);
                    tbl_wr.en         = req.has_stream_id;
                    tbl_wr.data       = SLOT_ACTIVE;
                    decision          = DEC_ADMITTED;
                end
                else if (backlog_room)
                begin
                    backlog_level_next = backlog_level_reg + COUNT_WIDTH'(1);
                    admitted_next      = sat_inc(admitted_reg);
                    tbl_wr.en          = req.has_stream_id;
                    tbl_wr.data        = SLOT_BACKLOG;
                    decision           = DEC_QUEUED;
                end
                else if (cfg.backlog_limit == '0)
                begin
                    active_hit_next = sat_inc(active_hit_reg);
                    shed_next       = sat_inc(shed_reg);
                    decision        = DEC_SHED_ACTIVE;
                end
                else
                begin
                    backlog_hit_next = sat_inc(backlog_hit_reg);
                    shed_next        = sat_inc(shed_reg);
                    decision         = DEC_SHED_BACKLOG;
                end
            end
            ACT_PROMOTE:
            begin
                if (req.has_stream_id && (slot == SLOT_BACKLOG) && active_room)
                begin
                    active_level_next = active_level_reg + COUNT_WIDTH'(1);
                    if (backlog_level_reg != '0)
                    begin
                        backlog_level_next = backlog_level_reg - COUNT_WIDTH'(1);
                    end
                    tbl_wr.en   = 1'b1;
                    tbl_wr.data = SLOT_ACTIVE;
                    promoted    = 1'b1;
                end
            end
            ACT_CLOSE:
            begin
                if (req.has_stream_id)
                begin
                    if (slot != SLOT_ABSENT)
                    begin
                        tbl_wr.en   = 1'b1;
                        tbl_wr.data = SLOT_ABSENT;
                        // The unused code is released as a backlog slot.
                        if (slot == SLOT_ACTIVE)
                        begin
                            if (active_level_reg != '0)
                            begin
                                active_level_next = active_level_reg - COUNT_WIDTH'(1);
                            end
                        end
                        else if (backlog_level_reg != '0)
                        begin
                            backlog_level_next = backlog_level_reg - COUNT_WIDTH'(1);
                        end
                    end
                end
                else if (active_level_reg != '0)
                begin
                    active_level_next = active_level_reg - COUNT_WIDTH'(1);
                end
                else if (backlog_level_reg != '0)
                begin
                    backlog_level_next = backlog_level_reg - COUNT_WIDTH'(1);
                end
            end
            ACT_SHUTDOWN:
            begin
                shutdown_next = req.shutdown_value;
            end
            default:
            begin
                shutdown_next = shutdown_reg;
            end
        endcase

        active_mark_next  = (active_level_next > active_mark_reg)
                          ? active_level_next : active_mark_reg;
        backlog_mark_next = (backlog_level_next > backlog_mark_reg)
                          ? backlog_level_next : backlog_mark_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg  <= '0;
            backlog_level_reg <= '0;
            active_mark_reg   <= '0;
            backlog_mark_reg  <= '0;
            offered_reg       <= '0;
            admitted_reg      <= '0;
            active_hit_reg    <= '0;
            backlog_hit_reg   <= '0;
            shed_reg          <= '0;
            shutdown_reg      <= 1'b0;
        end
        else if (advance)
        begin
            active_level_reg  <= active_level_next;
            backlog_level_reg <= backlog_level_next;
            active_mark_reg   <= active_mark_next;
            backlog_mark_reg  <= backlog_mark_next;
            offered_reg       <= offered_next;
            admitted_reg      <= admitted_next;
            active_hit_reg    <= active_hit_next;
            backlog_hit_reg   <= backlog_hit_next;
            shed_reg          <= shed_next;
            shutdown_reg      <= shutdown_next;
        end
    end

    always_comb
    begin
        result.decision              = decision;
        result.promoted              = promoted;
        result.active_now            = OUT_LEVEL_W'(active_level_next);
        result.backlog_now           = OUT_LEVEL_W'(backlog_level_next);
        result.active_high           = OUT_LEVEL_W'(active_mark_next);
        result.backlog_high          = OUT_LEVEL_W'(backlog_mark_next);
        result.offered_total         = offered_next;
        result.admitted_total        = admitted_next;
        result.active_cap_hit_total  = active_hit_next;
        result.backlog_cap_hit_total = backlog_hit_next;
        result.shed_total            = shed_next;
        result.shutdown_flag         = shutdown_next;
    end

endmodule

// ===== rtl/stream_admission_controller_core.sv =====
// Top level of the stream admission controller.
//
//  channel  direction  payload     transfers when
//  req      in         req_t       req.valid && req.ready
//  res      out        result_t    res.valid && res.ready
//  cfg      in         index/data  cfg_write high
//
// The input register and the slot table read register load at the edge that
// accepts a request; the decision logic fills the result register from them
// once it is free or its result is taken. One request per cycle is sustained
// while results are taken. Reset clears the slot table valid bits at once, with
// no clearing pass. While a result waits untaken, the next request still enters
// the input register; further requests stall until the result register frees up.
module stream_admission_controller_core #(
    parameter int NUM_STREAMS = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    sac_req_if.sink                              req,
    sac_res_if.source                            res,
    input  logic                                 cfg_write,
    input  sac_pkg::cfg_index_t                  cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sac_pkg::*;

    localparam int TABLE_DEPTH = (NUM_STREAMS < INDEX_SPAN) ? NUM_STREAMS : INDEX_SPAN;
    localparam int AW          = $clog2(TABLE_DEPTH);

    cfg_t    cfg_reg;
    logic    s1_valid_reg;
    req_t    s1_req_reg;
    logic [AW-1:0] s1_addr_reg;
    logic    out_valid_reg;
    result_t out_res_reg;

    logic    advance;
    logic    accept;
    slot_t   slot;
    result_t result;
    tbl_wr_t tbl_wr;
    logic [AW-1:0] idx_map [INDEX_SPAN];
    logic [AW-1:0] in_addr;

    // Stream index folded onto the table depth, worked out at elaboration.
    for (genvar g = 0; g < INDEX_SPAN; g++)
    begin : g_idx_map
        assign idx_map[g] = AW'(g % NUM_STREAMS);
    end

    assign in_addr   = idx_map[req.payload.stream_index];
    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ACTIVE_CAP:     cfg_reg.active_limit       <= cfg_data;
                CFG_BACKLOG_CAP:    cfg_reg.backlog_limit      <= cfg_data;
                CFG_DYNAMIC_CAP:    cfg_reg.dynamic_cap        <= cfg_data;
                CFG_DYNAMIC_CAP_EN: cfg_reg.dynamic_cap_enable <= cfg_data[0];
                default:            cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg  <= req.payload;
            s1_addr_reg <= in_addr;
        end
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    sac_slot_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_slot_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (slot),
        .wr_en   (advance && tbl_wr.en),
        .wr_addr (s1_addr_reg),
        .wr_data (tbl_wr.data)
    );

    sac_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (s1_req_reg),
        .slot    (slot),
        .cfg     (cfg_reg),
        .result  (result),
        .tbl_wr  (tbl_wr)
    );

    assign res.valid   = out_valid_reg;
    assign res.payload = out_res_reg;

endmodule

// ===== rtl/sac_checker.sv =====
// Port-level checker of the stream admission controller and its bind.
`include "stream_admission_controller_core_defines.svh"

module sac_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  logic             res_ready,
    input  sac_pkg::result_t res_payload
);
    import sac_pkg::*;

    logic               res_fire;
    logic               res_wait;
    logic               peak_ok;
    logic               totals_rise;
    logic               outcomes_ok;
    logic               seen_reg;
    logic [TOTAL_W-1:0] prev_offered_reg;
    logic [TOTAL_W-1:0] prev_shed_reg;

    assign res_fire = res_valid && res_ready;
    assign res_wait = res_valid && !res_ready;

    assign peak_ok     = (res_payload.active_high >= res_payload.active_now)
                      && (res_payload.backlog_high >= res_payload.backlog_now);
    assign totals_rise = (res_payload.offered_total >= prev_offered_reg)
                      && (res_payload.shed_total >= prev_shed_reg);
    assign outcomes_ok = (res_payload.admitted_total <= res_payload.offered_total)
                      && (res_payload.shed_total <= res_payload.offered_total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (res_fire)
        begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            prev_offered_reg <= res_payload.offered_total;
            prev_shed_reg    <= res_payload.shed_total;
        end
    end

    `SAC_ASSERT_NXT(a_res_hold, res_wait, res_valid && $stable(res_payload), "result not held")

    `SAC_ASSERT_IMP(a_peak_covers_level, res_fire, peak_ok, "peak below current level")

    `SAC_ASSERT_IMP(a_totals_monotonic, res_fire && seen_reg, totals_rise, "event total went backwards")

    `SAC_ASSERT_IMP(a_outcomes_within_offered, res_fire, outcomes_ok, "outcome total above offered")

endmodule

bind stream_admission_controller_core sac_checker u_sac_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_payload (res.payload)
);

// ===== dv/tb_stream_admission_controller_core.sv =====
// Self-checking testbench for the stream admission controller core.
module tb_stream_admission_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sac_pkg::*;

    localparam int IDLE_PCT       = 33;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SINK_HOLD      = 300;

    typedef logic [OUT_LEVEL_W-1:0] level_t;
    typedef logic [TOTAL_W-1:0]     total_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_write;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sac_req_if req_ch ();
    sac_res_if res_ch ();

    stream_admission_controller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Admission state as the block should hold it.
    slot_t  stream_slots [INDEX_SPAN];
    level_t active_level  = '0;
    level_t backlog_level = '0;
    level_t active_mark   = '0;
    level_t backlog_mark  = '0;
    total_t offered_cnt   = '0;
    total_t admitted_cnt  = '0;
    total_t active_hit_cnt  = '0;
    total_t backlog_hit_cnt = '0;
    total_t shed_cnt      = '0;
    logic   shutdown_on   = 1'b0;

    level_t cap_active  = '0;
    level_t cap_backlog = '0;
    level_t cap_dynamic = '0;
    logic   cap_dyn_en  = 1'b0;

    req_t    pending_requests [$];
    result_t predicted_results [$];

    int  errors   = 0;
    int  reported = 0;
    bit  no_idle  = 1'b0;
    int  hold_seq = 0;
    int  hold_seq_seen = 0;
    int  hold_left = 0;
    bit  req_fire_q = 1'b0;
    int  stall_cycles = 0;

    function automatic total_t sat_bump(input total_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic level_t level_drop(input level_t l);
        return (l == '0) ? l : l - 1'b1;
    endfunction

    // Claims one slot of a level bounded by limit and by its own width.
    function automatic bit claim_slot(inout level_t lvl, inout level_t mark,
                                      input level_t limit);
        if (lvl >= limit || lvl == '1)
            return 1'b0;
        lvl = lvl + 1'b1;
        if (lvl > mark)
            mark = lvl;
        return 1'b1;
    endfunction

    function automatic result_t admission_step(input req_t r);
        result_t o;
        level_t  limit;
        slot_t   prior;
        o = '0;
        o.decision = DEC_ADMITTED;
        limit = (cap_dyn_en && cap_dynamic < cap_active) ? cap_dynamic : cap_active;
        case (r.action)
            ACT_ADMIT:
            begin
                offered_cnt = sat_bump(offered_cnt);
                if (shutdown_on)
                begin
                    shed_cnt = sat_bump(shed_cnt);
                    o.decision = DEC_SHED_ACTIVE;
                end
                else if (claim_slot(active_level, active_mark, limit))
                begin
                    admitted_cnt = sat_bump(admitted_cnt);
                    if (r.has_stream_id)
                        stream_slots[r.stream_index] = SLOT_ACTIVE;
                end
                else if (claim_slot(backlog_level, backlog_mark, cap_backlog))
                begin
                    admitted_cnt = sat_bump(admitted_cnt);
                    if (r.has_stream_id)
                        stream_slots[r.stream_index] = SLOT_BACKLOG;
                    o.decision = DEC_QUEUED;
                end
                else if (cap_backlog == '0)
                begin
                    active_hit_cnt = sat_bump(active_hit_cnt);
                    shed_cnt = sat_bump(shed_cnt);
                    o.decision = DEC_SHED_ACTIVE;
                end
                else
                begin
                    backlog_hit_cnt = sat_bump(backlog_hit_cnt);
                    shed_cnt = sat_bump(shed_cnt);
                    o.decision = DEC_SHED_BACKLOG;
                end
            end
            ACT_PROMOTE:
            begin
                if (r.has_stream_id && stream_slots[r.stream_index] == SLOT_BACKLOG)
                begin
                    if (claim_slot(active_level, active_mark, limit))
                    begin
                        stream_slots[r.stream_index] = SLOT_ACTIVE;
                        backlog_level = level_drop(backlog_level);
                        o.promoted = 1'b1;
                    end
                end
            end
            ACT_CLOSE:
            begin
                if (r.has_stream_id)
                begin
                    prior = stream_slots[r.stream_index];
                    if (prior != SLOT_ABSENT)
                    begin
                        stream_slots[r.stream_index] = SLOT_ABSENT;
                        if (prior == SLOT_ACTIVE)
                            active_level = level_drop(active_level);
                        else
                            backlog_level = level_drop(backlog_level);
                    end
                end
                else if (active_level != '0)
                    active_level = level_drop(active_level);
                else
                    backlog_level = level_drop(backlog_level);
            end
            default:
                shutdown_on = r.shutdown_value;
        endcase
        o.active_now            = active_level;
        o.backlog_now           = backlog_level;
        o.active_high           = active_mark;
        o.backlog_high          = backlog_mark;
        o.offered_total         = offered_cnt;
        o.admitted_total        = admitted_cnt;
        o.active_cap_hit_total  = active_hit_cnt;
        o.backlog_cap_hit_total = backlog_hit_cnt;
        o.shed_total            = shed_cnt;
        o.shutdown_flag         = shutdown_on;
        return o;
    endfunction

    function automatic bit field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want === got)
            return 1'b0;
        if (reported < 10)
            $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
        return 1'b1;
    endfunction

    function automatic void compare_result(input result_t want, input result_t got);
        bit bad;
        bad = 1'b0;
        bad |= field_differs("decision", 32'(want.decision), 32'(got.decision));
        bad |= field_differs("promoted", 32'(want.promoted), 32'(got.promoted));
        bad |= field_differs("active_now", 32'(want.active_now), 32'(got.active_now));
        bad |= field_differs("backlog_now", 32'(want.backlog_now), 32'(got.backlog_now));
        bad |= field_differs("active_high", 32'(want.active_high), 32'(got.active_high));
        bad |= field_differs("backlog_high", 32'(want.backlog_high),
                             32'(got.backlog_high));
        bad |= field_differs("offered_total", want.offered_total, got.offered_total);
        bad |= field_differs("admitted_total", want.admitted_total, got.admitted_total);
        bad |= field_differs("active_cap_hit_total", want.active_cap_hit_total,
                             got.active_cap_hit_total);
        bad |= field_differs("backlog_cap_hit_total", want.backlog_cap_hit_total,
                             got.backlog_cap_hit_total);
        bad |= field_differs("shed_total", want.shed_total, got.shed_total);
        bad |= field_differs("shutdown_flag", 32'(want.shutdown_flag),
                             32'(got.shutdown_flag));
        if (bad)
        begin
            errors++;
            reported++;
        end
    endfunction

    // Request driver: a request stays offered until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_fire_q)
        begin
            if (pending_requests.size() > 0 &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                req_ch.valid   <= 1'b1;
                req_ch.payload <= pending_requests.pop_front();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result receiver, with an occasional long hold-off.
    always @(negedge clk)
    begin
        if (hold_seq_seen != hold_seq)
        begin
            hold_seq_seen <= hold_seq;
            hold_left     <= SINK_HOLD;
            res_ch.ready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: predicts on each accepted request and checks each result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_fire_q <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
                predicted_results.push_back(admission_step(req_ch.payload));
            if (res_ch.valid && res_ch.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    errors++;
                    if (reported < 10)
                        $display("%0t: result with no request outstanding", $realtime);
                    reported++;
                end
                else
                    compare_result(predicted_results.pop_front(), res_ch.payload);
            end
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_ACTIVE_CAP:  cap_active  = data;
            CFG_BACKLOG_CAP: cap_backlog = data;
            CFG_DYNAMIC_CAP: cap_dynamic = data;
            default:         cap_dyn_en  = data[0];
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_limits(input level_t act, input level_t blg, input level_t dyn,
                              input bit en);
        logic [CFG_DATA_W-1:0] en_word;
        // Upper bits of the enable word are don't-care and get random values.
        en_word = CFG_DATA_W'($urandom_range(0, 65535));
        en_word[0] = en;
        write_reg(CFG_ACTIVE_CAP, act);
        write_reg(CFG_BACKLOG_CAP, blg);
        write_reg(CFG_DYNAMIC_CAP, dyn);
        write_reg(CFG_DYNAMIC_CAP_EN, en_word);
    endtask

    task automatic push_request(input action_t act, input int idx, input bit named,
                                input bit sd);
        req_t r;
        r.action         = act;
        r.stream_index   = STREAM_INDEX_W'(idx);
        r.has_stream_id  = named;
        r.shutdown_value = sd;
        pending_requests.push_back(r);
    endtask

    // Mostly named requests on a small set of streams, so that promotes and
    // closes find listed entries; the rest are anonymous or scattered.
    task automatic push_random_request(input int pool_base);
        req_t r;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 38)
            r.action = ACT_ADMIT;
        else if (roll < 62)
            r.action = ACT_PROMOTE;
        else if (roll < 92)
            r.action = ACT_CLOSE;
        else
            r.action = ACT_SHUTDOWN;
        r.has_stream_id = ($urandom_range(0, 99) < 80);
        if ($urandom_range(0, 99) < 85)
            r.stream_index = STREAM_INDEX_W'(pool_base + $urandom_range(0, 11));
        else
            r.stream_index = STREAM_INDEX_W'($urandom_range(0, 255));
        if (r.action == ACT_SHUTDOWN)
            r.shutdown_value = ($urandom_range(0, 99) < 35);
        else
            r.shutdown_value = 1'($urandom_range(0, 1));
        pending_requests.push_back(r);
    endtask

    // Returns once every request has been taken and every result checked.
    task automatic wait_drained();
        while (pending_requests.size() > 0 || req_ch.valid || predicted_results.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input level_t act, input level_t blg, input level_t dyn,
                             input bit en, input int count, input bit steady,
                             input bit hold);
        int pool_base;
        set_limits(act, blg, dyn, en);
        no_idle = steady;
        pool_base = $urandom_range(0, 255);
        repeat (count)
            push_random_request(pool_base);
        if (hold)
            hold_seq++;
        wait_drained();
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_ACTIVE_CAP;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        res_ch.ready   = 1'b0;
        foreach (stream_slots[i])
            stream_slots[i] = SLOT_ABSENT;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        set_limits(16'd2, 16'd1, 16'd0, 1'b0);
        push_request(ACT_ADMIT, 0, 1'b1, 1'b0);
        push_request(ACT_ADMIT, 255, 1'b1, 1'b1);
        push_request(ACT_ADMIT, 7, 1'b1, 1'b0);
        push_request(ACT_ADMIT, 42, 1'b0, 1'b1);     // backlog full: backlog-cap shed
        push_request(ACT_PROMOTE, 7, 1'b1, 1'b0);    // no room yet
        push_request(ACT_PROMOTE, 7, 1'b0, 1'b0);    // anonymous: nothing happens
        push_request(ACT_PROMOTE, 0, 1'b1, 1'b1);    // already active
        push_request(ACT_PROMOTE, 100, 1'b1, 1'b0);  // absent entry
        push_request(ACT_CLOSE, 0, 1'b1, 1'b0);
        push_request(ACT_PROMOTE, 7, 1'b1, 1'b1);    // now promoted
        push_request(ACT_CLOSE, 99, 1'b1, 1'b0);     // absent entry
        push_request(ACT_ADMIT, 255, 1'b1, 1'b0);    // re-admit overwrites the entry
        push_request(ACT_CLOSE, 0, 1'b0, 1'b1);
        push_request(ACT_CLOSE, 255, 1'b0, 1'b0);
        push_request(ACT_CLOSE, 128, 1'b0, 1'b0);    // anonymous close falls to backlog
        push_request(ACT_CLOSE, 1, 1'b0, 1'b1);      // both levels already zero
        push_request(ACT_CLOSE, 255, 1'b1, 1'b0);
        push_request(ACT_CLOSE, 7, 1'b1, 1'b1);
        push_request(ACT_SHUTDOWN, 0, 1'b0, 1'b1);
        push_request(ACT_ADMIT, 3, 1'b1, 1'b0);      // shed by shutdown
        push_request(ACT_CLOSE, 3, 1'b0, 1'b0);
        push_request(ACT_SHUTDOWN, 255, 1'b1, 1'b0);
        push_request(ACT_ADMIT, 200, 1'b0, 1'b1);
        wait_drained();

        run_phase(16'd4, 16'd3, 16'd2, 1'b1, 250, 1'b0, 1'b0);
        run_phase(16'd8, 16'd0, 16'hFFFF, 1'b1, 250, 1'b0, 1'b1);
        run_phase(16'd0, 16'd5, 16'd0, 1'b0, 200, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'd3, 1'b1, 250, 1'b1, 1'b0);
        run_phase(16'd16, 16'd8, 16'hFFFF, 1'b0, 250, 1'b0, 1'b0);
        run_phase(16'd3, 16'd2, 16'd0, 1'b1, 200, 1'b0, 1'b0);
        run_phase(16'd1, 16'd1, 16'd1, 1'b1, 250, 1'b0, 1'b1);
        run_phase(16'd6, 16'hFFFF, 16'd4, 1'b0, 250, 1'b0, 1'b0);

        // Wide caps with the dynamic cap ignored, admits back to back.
        set_limits(16'hFFFF, 16'hFFFF, 16'h0, 1'b0);
        no_idle = 1'b1;
        push_request(ACT_SHUTDOWN, 0, 1'b0, 1'b0);
        repeat (60)
            push_request(ACT_ADMIT, int'($urandom_range(0, 255)), 1'b0,
                         1'($urandom_range(0, 1)));
        push_request(ACT_ADMIT, 9, 1'b1, 1'b0);
        push_request(ACT_CLOSE, 0, 1'b0, 1'b0);
        push_request(ACT_ADMIT, 9, 1'b1, 1'b1);
        push_request(ACT_PROMOTE, 9, 1'b1, 1'b0);
        wait_drained();
        no_idle = 1'b0;

        repeat (10) @(negedge clk);
        if (predicted_results.size() > 0)
        begin
            errors++;
            $display("%0d results never arrived", predicted_results.size());
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== stream_admission_controller_core.f =====
+incdir+rtl
rtl/sac_pkg.sv
rtl/sac_if.sv
rtl/sac_slot_table.sv
rtl/sac_engine.sv
rtl/stream_admission_controller_core.sv
rtl/sac_checker.sv
dv/tb_stream_admission_controller_core.sv
